@@ rtl/lcsg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcsg_pkg
// Shared widths, register indexes and types of the load-cell spike guard.
// ----------------------------------------------------------------------------
package lcsg_pkg;

  localparam int SampleW  = 24;
  localparam int TimeW    = 32;
  localparam int ScaleW   = 24;
  localparam int ThreshW  = 16;
  localparam int TimeoutW = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;
  // threshold * scale
  localparam int RhsW     = ThreshW + ScaleW;
  // |difference| needs one bit more than a sample
  localparam int MagW     = SampleW + 1;
  // |d| / (q8/256) >= thr/16  <=>  |d| * 4096 >= thr * q8
  localparam int MagShift = 12;

  // scale at or below this value (2/256 counts per gram) means uncalibrated
  localparam logic [ScaleW-1:0] UncalMaxQ8 = ScaleW'(2);

  localparam logic [ScaleW-1:0]   ScaleReset   = '0;
  localparam logic [ThreshW-1:0]  ThreshReset  = ThreshW'(160);
  localparam logic [TimeoutW-1:0] TimeoutReset = TimeoutW'(500);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COUNTS_PER_GRAM = 2'd0,
    CFG_JUMP_THRESHOLD  = 2'd1,
    CFG_PENDING_TIMEOUT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [ScaleW-1:0]   counts_per_gram_q8;
    logic [ThreshW-1:0]  jump_threshold;
    logic [TimeoutW-1:0] pending_timeout_ms;
    logic                uncal;
    logic [RhsW-1:0]     jump_rhs;
  } cfg_t;

  typedef struct packed {
    logic                      has_reference;
    logic signed [SampleW-1:0] last_good_sample;
    logic                      spike_pending;
    logic [TimeW-1:0]          pending_time;
  } guard_state_t;

endpackage
`default_nettype wire

@@ rtl/lcsg_sample_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcsg_sample_if
// Request channel carrying one load-cell sample and its timestamp.
// ----------------------------------------------------------------------------
interface lcsg_sample_if import lcsg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] raw_sample;
  logic [TimeW-1:0]          now_ms;

  modport source (output valid, output raw_sample, output now_ms, input ready);
  modport sink   (input valid, input raw_sample, input now_ms, output ready);
endinterface
`default_nettype wire

@@ rtl/lcsg_result_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcsg_result_if
// Result channel: pass/drop decision and the passed sample.
// ----------------------------------------------------------------------------
interface lcsg_result_if import lcsg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      accepted;
  logic signed [SampleW-1:0] out_sample;

  modport source (output valid, output accepted, output out_sample, input ready);
  modport sink   (input valid, input accepted, input out_sample, output ready);
endinterface
`default_nettype wire

@@ rtl/lcsg_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcsg_cfg_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface lcsg_cfg_if import lcsg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/lcsg_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcsg_cfg
// Configuration registers. Also keeps the threshold*scale product and the
// uncalibrated flag registered, so the per-sample path only compares.
// ----------------------------------------------------------------------------
module lcsg_cfg import lcsg_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  lcsg_cfg_if.sink    cfg,
  output cfg_t        regs
);

  logic [ScaleW-1:0]   scale_next;
  logic [ThreshW-1:0]  thresh_next;
  logic [TimeoutW-1:0] timeout_next;

  assign cfg.ready = 1'b1;

  always_comb begin
    scale_next   = regs.counts_per_gram_q8;
    thresh_next  = regs.jump_threshold;
    timeout_next = regs.pending_timeout_ms;
    if (cfg.valid) begin
      unique case (cfg.index)
        CFG_COUNTS_PER_GRAM: scale_next   = cfg.data[ScaleW-1:0];
        CFG_JUMP_THRESHOLD:  thresh_next  = cfg.data[ThreshW-1:0];
        CFG_PENDING_TIMEOUT: timeout_next = cfg.data[TimeoutW-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.counts_per_gram_q8 <= ScaleReset;
      regs.jump_threshold     <= ThreshReset;
      regs.pending_timeout_ms <= TimeoutReset;
      regs.uncal              <= 1'b1;
      regs.jump_rhs           <= RhsW'(ThreshReset) * RhsW'(ScaleReset);
    end else begin
      regs.counts_per_gram_q8 <= scale_next;
      regs.jump_threshold     <= thresh_next;
      regs.pending_timeout_ms <= timeout_next;
      regs.uncal              <= (scale_next <= UncalMaxQ8);
      regs.jump_rhs           <= RhsW'(thresh_next) * RhsW'(scale_next);
    end
  end

endmodule
`default_nettype wire

@@ rtl/lcsg_judge.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcsg_judge
// Pass/drop decision for one sample and the guard state that follows it.
// ----------------------------------------------------------------------------
module lcsg_judge import lcsg_pkg::*; (
  input  wire cfg_t                 regs,
  input  wire guard_state_t         cur,
  input  wire logic signed [SampleW-1:0] raw_sample,
  input  wire logic [TimeW-1:0]     now_ms,
  output logic                      accepted,
  output logic signed [SampleW-1:0] out_sample,
  output guard_state_t              nxt
);

  logic signed [MagW-1:0] diff;
  logic [MagW-1:0]        mag;
  logic [RhsW-1:0]        lhs;
  logic [TimeW-1:0]       age;
  logic                   pending_live;
  logic                   is_jump;

  always_comb begin
    diff = MagW'(raw_sample) - MagW'(cur.last_good_sample);
    mag  = diff[MagW-1] ? MagW'(-diff) : MagW'(diff);
    lhs  = RhsW'({mag, MagShift'(0)});
    is_jump = (lhs >= regs.jump_rhs);

    // age wraps mod 2^32
    age = now_ms - cur.pending_time;
    pending_live = cur.spike_pending && (age <= TimeW'(regs.pending_timeout_ms));

    nxt        = cur;
    accepted   = 1'b1;
    out_sample = raw_sample;

    if (regs.uncal) begin
      // pass through, state untouched
    end else if (!cur.has_reference) begin
      nxt.has_reference    = 1'b1;
      nxt.last_good_sample = raw_sample;
      nxt.spike_pending    = 1'b0;
    end else if (!pending_live && is_jump) begin
      nxt.spike_pending = 1'b1;
      nxt.pending_time  = now_ms;
      accepted          = 1'b0;
      out_sample        = '0;
    end else begin
      nxt.spike_pending    = 1'b0;
      nxt.last_good_sample = raw_sample;
    end
  end

endmodule
`default_nettype wire

@@ rtl/load_cell_spike_guard.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// load_cell_spike_guard
// Drops single-sample jumps in a load-cell stream; the sample after a drop
// passes unless the drop has expired. Pending drops expire after a programmable age.
// ----------------------------------------------------------------------------
//  port      dir   payload                         accepted when
//  samples   in    raw_sample[23:0], now_ms[31:0]  valid & ready
//  results   out   accepted, out_sample[23:0]      valid & ready
//  cfg       in    index[1:0], data[23:0]          valid & ready (ready tied 1)
//
//  One request per cycle sustained while results are taken. Stages: input
//  register, then decision into the result register. The rate is set by
//  the single decision stage, which updates the guard state once per request.
//  Reset (rst) is synchronous; all but the payload registers return to defaults.
//  A stalled result holds both stages; a free result slot keeps samples.ready up.
// ----------------------------------------------------------------------------
module load_cell_spike_guard import lcsg_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  lcsg_cfg_if.sink      cfg,
  lcsg_sample_if.sink   samples,
  lcsg_result_if.source results
);

  cfg_t                      regs;
  guard_state_t              state;
  guard_state_t              state_next;

  logic                      s1_valid;
  logic signed [SampleW-1:0] s1_sample;
  logic [TimeW-1:0]          s1_time;

  logic                      res_valid;
  logic                      res_accepted;
  logic signed [SampleW-1:0] res_sample;

  logic                      dec_accepted;
  logic signed [SampleW-1:0] dec_sample;
  logic                      advance;

  lcsg_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  lcsg_judge u_judge (
    .regs       (regs),
    .cur        (state),
    .raw_sample (s1_sample),
    .now_ms     (s1_time),
    .accepted   (dec_accepted),
    .out_sample (dec_sample),
    .nxt        (state_next)
  );

  assign advance       = !res_valid || results.ready;
  assign samples.ready = !s1_valid || advance;

  assign results.valid      = res_valid;
  assign results.accepted   = res_accepted;
  assign results.out_sample = res_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
      state.has_reference    <= 1'b0;
      state.spike_pending    <= 1'b0;
      state.last_good_sample <= '0;
      state.pending_time     <= '0;
    end else begin
      if (samples.ready) begin
        s1_valid <= samples.valid;
      end
      if (advance) begin
        res_valid <= s1_valid;
      end
      if (s1_valid && advance) begin
        state.has_reference    <= state_next.has_reference;
        state.spike_pending    <= state_next.spike_pending;
        state.last_good_sample <= state_next.last_good_sample;
        state.pending_time     <= state_next.pending_time;
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (samples.ready && samples.valid) begin
      s1_sample <= samples.raw_sample;
      s1_time   <= samples.now_ms;
    end
    if (s1_valid && advance) begin
      res_accepted <= dec_accepted;
      res_sample   <= dec_sample;
    end
  end

endmodule
`default_nettype wire

@@ sim/load_cell_spike_guard_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_cell_spike_guard_tb
// Self-checking bench for the load-cell spike guard. Samples are offered in
// random bursts while the result side stalls on its own pattern. Each
// accepted request is fed to a fixed-point model of the guard (seed, drop,
// forced accept after a drop, expiry of a held spike, uncalibrated bypass).
// Every result is compared against the oldest expected decision. The run
// steps through several calibration, threshold and timeout settings.
// ----------------------------------------------------------------------------
import lcsg_pkg::*;

typedef struct packed {
  logic                      accepted;
  logic signed [SampleW-1:0] out_sample;
} guard_result_t;

class spike_guard_scoreboard;
  logic [ScaleW-1:0]         counts_per_gram_q8;
  logic [ThreshW-1:0]        jump_threshold;
  logic [TimeoutW-1:0]       pending_timeout_ms;
  bit                        has_reference;
  logic signed [SampleW-1:0] last_good;
  bit                        spike_pending;
  logic signed [SampleW-1:0] pending_sample;
  logic [TimeW-1:0]          pending_since;
  guard_result_t             expected_q[$];
  int unsigned               failures;
  int unsigned               n_samples;
  int unsigned               n_results;
  int unsigned               n_dropped;
  int unsigned               n_uncal;
  int unsigned               n_expired;
  int unsigned               n_reg_writes;

  function new();
    counts_per_gram_q8 = ScaleReset;
    jump_threshold     = ThreshReset;
    pending_timeout_ms = TimeoutReset;
    has_reference      = 1'b0;
    last_good          = '0;
    spike_pending      = 1'b0;
    pending_sample     = '0;
    pending_since      = '0;
    failures           = 0;
    n_samples          = 0;
    n_results          = 0;
    n_dropped          = 0;
    n_uncal            = 0;
    n_expired          = 0;
    n_reg_writes       = 0;
  endfunction

  function void set_register(logic [CfgIdxW-1:0] index, logic [CfgDataW-1:0] data);
    n_reg_writes++;
    case (index)
      CFG_COUNTS_PER_GRAM: counts_per_gram_q8 = data[ScaleW-1:0];
      CFG_JUMP_THRESHOLD:  jump_threshold     = data[ThreshW-1:0];
      CFG_PENDING_TIMEOUT: pending_timeout_ms = data[TimeoutW-1:0];
      default: ;
    endcase
  endfunction

  // |x - anchor| * 4096 >= thr * q8, exact in 64 bits
  function bit is_jump(logic signed [SampleW-1:0] x, logic signed [SampleW-1:0] anchor);
    logic [MagW-1:0] diff;
    logic [MagW-1:0] mag;
    logic [63:0]     lhs;
    logic [63:0]     rhs;
    diff = {x[SampleW-1], x} - {anchor[SampleW-1], anchor};
    mag  = diff[MagW-1] ? -diff : diff;
    lhs  = 64'(mag) << MagShift;
    rhs  = 64'(jump_threshold) * 64'(counts_per_gram_q8);
    return lhs >= rhs;
  endfunction

  function void note_sample(logic signed [SampleW-1:0] raw, logic [TimeW-1:0] now);
    guard_result_t   r;
    logic [TimeW-1:0] age;
    n_samples++;
    r.accepted   = 1'b1;
    r.out_sample = raw;
    if (counts_per_gram_q8 <= UncalMaxQ8) begin
      n_uncal++;
    end else if (!has_reference) begin
      has_reference = 1'b1;
      last_good     = raw;
      spike_pending = 1'b0;
    end else begin
      age = now - pending_since;
      if (spike_pending && age > TimeW'(pending_timeout_ms)) begin
        spike_pending = 1'b0;
        n_expired++;
      end
      if (!spike_pending && is_jump(raw, last_good)) begin
        spike_pending  = 1'b1;
        pending_sample = raw;
        pending_since  = now;
        r              = '0;
        n_dropped++;
      end else begin
        spike_pending = 1'b0;
        last_good     = raw;
      end
    end
    expected_q.push_back(r);
  endfunction

  function void flag(string what);
    failures++;
    if (failures <= 10) $display("[%0t] MISMATCH: %s", $realtime, what);
  endfunction

  function void check_result(logic accepted, logic signed [SampleW-1:0] out_sample);
    guard_result_t want;
    n_results++;
    if (expected_q.size() == 0) begin
      flag($sformatf("result %0d with no request outstanding (accepted=%0b out_sample=%0d)",
                     n_results, accepted, out_sample));
      return;
    end
    want = expected_q.pop_front();
    if (accepted !== want.accepted)
      flag($sformatf("result %0d accepted: expected %0b, got %0b",
                     n_results, want.accepted, accepted));
    if (out_sample !== want.out_sample)
      flag($sformatf("result %0d out_sample: expected %0d, got %0d",
                     n_results, want.out_sample, out_sample));
  endfunction

  function void close();
    while (expected_q.size() != 0) begin
      void'(expected_q.pop_front());
      flag("expected result never arrived");
    end
  endfunction
endclass

module load_cell_spike_guard_tb;

  localparam int          ResetCycles    = 9;
  localparam int          PipeDepth      = 2;
  localparam int          PhaseCount     = 10;
  localparam int          PhaseItems     = 115;
  localparam int          PressurePhase  = 4;
  localparam int          LongHoldCycles = 80;
  localparam longint      RunLimitNs     = 2_000_000;
  // index with no register behind it; writes must be ignored
  localparam logic [CfgIdxW-1:0]  CfgIdxSpare = 2'd3;
  localparam logic signed [SampleW-1:0] SampleMaxV = 24'sh7FFFFF;
  localparam logic signed [SampleW-1:0] SampleMinV = 24'sh800000;

  typedef enum int unsigned {
    SINK_OPEN,
    SINK_LIGHT,
    SINK_HEAVY,
    SINK_PERIODIC
  } sink_mode_t;

  logic clk = 1'b0;
  logic rst;
  bit   hold_request = 1'b0;

  logic [ScaleW-1:0]   cur_q8;
  logic [ThreshW-1:0]  cur_thr;
  logic [TimeoutW-1:0] cur_tmo;
  longint              stim_base;
  logic [TimeW-1:0]    stim_now;

  spike_guard_scoreboard sb;

  lcsg_cfg_if    cfg_if();
  lcsg_sample_if samples_if();
  lcsg_result_if results_if();

  load_cell_spike_guard i_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_if),
    .samples (samples_if),
    .results (results_if)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && cfg_if.valid && cfg_if.ready)
      sb.set_register(cfg_if.index, cfg_if.data);
    if (!rst && samples_if.valid && samples_if.ready)
      sb.note_sample(samples_if.raw_sample, samples_if.now_ms);
    if (!rst && results_if.valid && results_if.ready)
      sb.check_result(results_if.accepted, results_if.out_sample);
  end

  // keeps valid high; caller lowers it after the last write
  task automatic cfg_write(input logic [CfgIdxW-1:0] index, input logic [CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic configure(input logic [ScaleW-1:0] q8, input logic [ThreshW-1:0] thr,
                           input logic [TimeoutW-1:0] tmo);
    // junk in the unused upper data bits must not leak into 16-bit registers
    cfg_write(CFG_COUNTS_PER_GRAM, q8);
    cfg_write(CFG_JUMP_THRESHOLD, {(CfgDataW-ThreshW)'($urandom), thr});
    cfg_write(CFG_PENDING_TIMEOUT, {(CfgDataW-TimeoutW)'($urandom), tmo});
    cfg_if.valid <= 1'b0;
    cur_q8  = q8;
    cur_thr = thr;
    cur_tmo = tmo;
  endtask

  task automatic send_sample(input logic signed [SampleW-1:0] raw, input logic [TimeW-1:0] now);
    samples_if.valid      <= 1'b1;
    samples_if.raw_sample <= raw;
    samples_if.now_ms     <= now;
    do @(posedge clk); while (!samples_if.ready);
  endtask

  task automatic drain();
    samples_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (PipeDepth + 2) @(posedge clk);
  endtask

  // mostly walks near the last sample, scaled to the current jump size, so
  // that drops, forced accepts and expiries all happen often
  task automatic gen_request(output logic signed [SampleW-1:0] raw, output logic [TimeW-1:0] now);
    longint                    span;
    longint                    v;
    int unsigned               pick;
    logic signed [SampleW-1:0] rnd;
    span = (longint'(cur_thr) * longint'(cur_q8)) >>> MagShift;
    if (span < 1) span = 1;
    if (span > 16777216) span = 16777216;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      v = stim_base + longint'($urandom_range(0, 32'(4 * span + 4))) - (2 * span + 2);
    end else if (pick < 80) begin
      v = span + longint'($urandom_range(0, 32'(span)));
      if ($urandom_range(0, 1) == 1) v = -v;
      v = stim_base + v;
    end else begin
      rnd = SampleW'($urandom);
      v   = longint'(rnd);
    end
    if (v > longint'(SampleMaxV)) v = longint'(SampleMaxV);
    if (v < longint'(SampleMinV)) v = longint'(SampleMinV);
    stim_base = v;
    raw = SampleW'(v);

    pick = $urandom_range(0, 99);
    if (pick < 65)
      stim_now = stim_now + $urandom_range(0, 2 * cur_tmo + 2);
    else if (pick < 80)
      stim_now = stim_now + {16'h0, cur_tmo} + $urandom_range(0, 1);
    else if (pick < 88)
      stim_now = $urandom;
    else if (pick < 94)
      stim_now = 32'hFFFF_FFFF - $urandom_range(0, 2 * cur_tmo + 2);
    now = stim_now;
  endtask

  task automatic run_bursts(input int unsigned count);
    int unsigned               left;
    int unsigned               burst;
    int unsigned               gap;
    logic signed [SampleW-1:0] raw;
    logic [TimeW-1:0]          now;
    left = count;
    while (left != 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) begin
        gen_request(raw, now);
        send_sample(raw, now);
      end
      left -= burst;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        samples_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // result side: stall pattern of its own, plus a long hold on request
  initial begin : result_sink
    sink_mode_t  mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned stall_phase;
    results_if.ready <= 1'b0;
    mode        = SINK_OPEN;
    mode_left   = 0;
    hold_left   = 0;
    stall_phase = 0;
    forever begin
      @(posedge clk);
      stall_phase++;
      if (hold_request) begin
        hold_left    = LongHoldCycles;
        hold_request = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        results_if.ready <= 1'b0;
      end else begin
        case (mode)
          SINK_OPEN:  results_if.ready <= 1'b1;
          SINK_LIGHT: results_if.ready <= ($urandom_range(0, 9) < 8);
          SINK_HEAVY: results_if.ready <= ($urandom_range(0, 9) < 3);
          default:    results_if.ready <= ((stall_phase % 3) != 0);
        endcase
      end
    end
  end

  initial begin
    logic signed [SampleW-1:0] raw;
    logic [TimeW-1:0]          now;
    sb = new();
    rst                   <= 1'b1;
    samples_if.valid      <= 1'b0;
    samples_if.raw_sample <= '0;
    samples_if.now_ms     <= '0;
    cfg_if.valid          <= 1'b0;
    cfg_if.index          <= '0;
    cfg_if.data           <= '0;
    cur_q8    = ScaleReset;
    cur_thr   = ThreshReset;
    cur_tmo   = TimeoutReset;
    stim_base = 0;
    stim_now  = '0;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // uncalibrated after reset: everything passes, no reference taken
    send_sample(SampleMinV, 32'h0);
    send_sample(SampleMaxV, 32'hFFFF_FFFF);
    send_sample(24'sd0, 32'd5);
    drain();
    configure(UncalMaxQ8, ThreshReset, TimeoutReset);
    send_sample(-24'sd1, 32'd6);
    drain();

    // 1 count per gram, 10 g threshold: jump means |d| >= 10
    configure(24'd256, 16'd160, 16'd500);
    send_sample(24'sd100, 32'd1000);        // seeds reference
    send_sample(24'sd109, 32'd1010);        // just under
    send_sample(24'sd119, 32'd1020);        // exactly at threshold: drop
    send_sample(SampleMinV, 32'd1030);      // within the timeout of a drop: passes
    send_sample(SampleMaxV, 32'd1040);      // full-scale jump: drop
    send_sample(SampleMaxV, 32'd1540);      // age equals timeout: still held
    send_sample(24'sd0, 32'd2000);          // drop
    send_sample(24'sd0, 32'd2501);          // held spike expired, drop again
    send_sample(24'sd5, 32'd2600);
    send_sample(24'sd5000, 32'hFFFF_FF00);  // drop just before wrap
    send_sample(24'sd4990, 32'h0000_0010);  // age across wrap is small
    drain();

    // zero threshold: every judged sample is a jump; zero timeout
    configure(24'd3, 16'd0, 16'd0);
    send_sample(24'sd4990, 32'd20);
    send_sample(24'sd1, 32'd20);
    send_sample(24'sd1, 32'd22);
    send_sample(24'sd2, 32'd23);
    drain();

    cfg_write(CfgIdxSpare, CfgDataW'($urandom));
    configure('1, '1, '1);
    send_sample(SampleMinV, 32'd100);
    send_sample(SampleMaxV, 32'd200);
    drain();

    stim_base = longint'(SampleMaxV);
    stim_now  = 32'd200;
    for (int p = 0; p < PhaseCount; p++) begin
      if (p == 0)
        configure(ScaleW'($urandom_range(0, 2)), ThreshW'($urandom), TimeoutW'($urandom));
      else if (p == 1)
        configure(24'd3, ThreshW'($urandom_range(0, 200)), '0);
      else if (p == PhaseCount - 2)
        configure('1, 16'd1, TimeoutW'($urandom_range(1, 1000)));
      else if (p == PhaseCount - 1)
        configure('1, '1, '1);
      else
        configure(ScaleW'($urandom_range(3, 65536)), ThreshW'($urandom_range(0, 2000)),
                  ($urandom_range(0, 3) == 0) ? TimeoutW'(0) :
                  ($urandom_range(0, 2) == 0) ? TimeoutW'(16'hFFFF) :
                                                TimeoutW'($urandom_range(1, 1000)));
      if (p == PressurePhase) begin
        run_bursts(50);
        drain();
        // hold the result side while requests keep coming back to back
        hold_request = 1'b1;
        repeat (24) begin
          gen_request(raw, now);
          send_sample(raw, now);
        end
        run_bursts(PhaseItems - 74);
      end else begin
        run_bursts(PhaseItems);
      end
      drain();
    end

    sb.close();
    $display("Covered %0d samples over %0d register writes:",
             sb.n_samples, sb.n_reg_writes);
    $display("  %0d dropped, %0d expired, %0d bypassed",
             sb.n_dropped, sb.n_expired, sb.n_uncal);
    if (sb.failures == 0) begin
      $display("load_cell_spike_guard verification clean");
    end else begin
      $display("%0d mismatches", sb.failures);
      $display("load_cell_spike_guard verification failed");
    end
    $finish;
  end

  initial begin
    #(RunLimitNs);
    $display("timeout: results did not drain");
    $display("load_cell_spike_guard verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/lcsg_pkg.sv
rtl/lcsg_sample_if.sv
rtl/lcsg_result_if.sv
rtl/lcsg_cfg_if.sv
rtl/lcsg_cfg.sv
rtl/lcsg_judge.sv
rtl/load_cell_spike_guard.sv
sim/load_cell_spike_guard_tb.sv
